### rtl/hca_pkg.sv
// hca_pkg: shared constants for the HSV color adjust block.
// Register map codes and fixed offset register widths; no dependencies.
package hca_pkg;

  localparam int HUE_OFS_W = 17;
  localparam int SV_OFS_W  = 9;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [1:0] REG_HUE_OFS = 2'd0;
  localparam logic [1:0] REG_SAT_OFS = 2'd1;
  localparam logic [1:0] REG_VAL_OFS = 2'd2;

endpackage

### rtl/hca_if.sv
// hca_if: pixel stream interfaces (valid/ready plus RGB payload).
// Used by the hsv_color_adjust top level; no package dependency.
interface hca_in_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_in;
  logic [W-1:0] green_in;
  logic [W-1:0] blue_in;
  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface hca_out_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

### rtl/hca_div.sv
// hca_div: pipelined restoring divider, one quotient bit per stage.
// Dividend high part must be below the divisor; carries a sideband word.
module hca_div #(
  parameter int BW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [BW+QW-1:0]   dividend,
  input  logic [BW-1:0]      divisor,
  input  logic [SW-1:0]      side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quotient,
  output logic [SW-1:0]      side_out
);

  logic [QW-1:0] vld;
  logic [BW-1:0] rem  [QW];
  logic [QW-1:0] lo   [QW];
  logic [BW-1:0] dvs  [QW];
  logic [SW-1:0] side [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic          p_v;
    logic [BW-1:0] p_rem;
    logic [QW-1:0] p_lo;
    logic [BW-1:0] p_dvs;
    logic [SW-1:0] p_side;
    logic [BW:0]   shifted;
    logic [BW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign p_v    = in_valid;
      assign p_rem  = dividend[BW+QW-1:QW];
      assign p_lo   = dividend[QW-1:0];
      assign p_dvs  = divisor;
      assign p_side = side_in;
    end else begin : g_next
      assign p_v    = vld[k-1];
      assign p_rem  = rem[k-1];
      assign p_lo   = lo[k-1];
      assign p_dvs  = dvs[k-1];
      assign p_side = side[k-1];
    end

    // low word shifts out dividend bits and fills with quotient bits
    assign shifted = {p_rem, p_lo[QW-1]};
    assign diff    = shifted - {1'b0, p_dvs};
    assign ge      = shifted >= {1'b0, p_dvs};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[BW-1:0] : shifted[BW-1:0];
        lo[k]   <= (p_lo << 1) | QW'(ge);
        dvs[k]  <= p_dvs;
        side[k] <= p_side;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign quotient  = lo[QW-1];
  assign side_out  = side[QW-1];

endmodule

### rtl/hca_rgb2hsv.sv
// hca_rgb2hsv: RGB to HSV front end (max/min stage, saturation and hue dividers).
// Depends on hca_div.
module hca_rgb2hsv #(
  parameter int C = 8,
  parameter int H = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  logic [C-1:0] red,
  input  logic [C-1:0] green,
  input  logic [C-1:0] blue,
  output logic         out_valid,
  output logic [H-1:0] hue,
  output logic [C-1:0] sat,
  output logic [C-1:0] val
);

  localparam int NW  = C + 3;
  localparam int SW1 = C + 2 * NW;
  localparam int SW2 = 2 * C + 1;

  logic [C-1:0]   mx, mn, d;
  logic [NW-1:0]  d6;
  logic signed [NW+1:0] num;

  logic           f_v;
  logic [C-1:0]   f_mx;
  logic [NW-1:0]  f_d6;
  logic [NW-1:0]  f_num;
  logic [2*C-1:0] f_dcm;

  logic           s_v;
  logic [C-1:0]   s_q;
  logic [SW1-1:0] s_side;
  logic [C-1:0]   s_mx;
  logic [NW-1:0]  s_num;
  logic [NW-1:0]  s_d6;
  logic [C-1:0]   s_sat;

  logic [H-1:0]   h_q;
  logic [SW2-1:0] h_side;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    d  = mx - mn;
    d6 = (NW'(d) << 2) + (NW'(d) << 1);
    // ties go to red, then green
    if (red == mx) begin
      num = $signed({2'b0, NW'(green)}) - $signed({2'b0, NW'(blue)});
    end else if (green == mx) begin
      num = $signed({2'b0, NW'(d) << 1}) + $signed({2'b0, NW'(blue)})
          - $signed({2'b0, NW'(red)});
    end else begin
      num = $signed({2'b0, NW'(d) << 2}) + $signed({2'b0, NW'(red)})
          - $signed({2'b0, NW'(green)});
    end
    if (num < 0) num = num + $signed({2'b0, d6});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (en) begin
      f_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_mx  <= mx;
      f_d6  <= d6;
      f_num <= num[NW-1:0];
      f_dcm <= ({C'(0), d} << C) - {C'(0), d};
    end
  end

  hca_div #(.BW(C), .QW(C), .SW(SW1)) u_sat_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_v),
    .dividend  (f_dcm),
    .divisor   (f_mx),
    .side_in   ({f_mx, f_num, f_d6}),
    .out_valid (s_v),
    .quotient  (s_q),
    .side_out  (s_side)
  );

  assign {s_mx, s_num, s_d6} = s_side;
  assign s_sat = (s_mx == '0) ? '0 : s_q;

  hca_div #(.BW(NW), .QW(H), .SW(SW2)) u_hue_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_v),
    .dividend  ({s_num, H'(0)}),
    .divisor   (s_d6),
    .side_in   ({s_sat, s_mx, (s_d6 == '0)}),
    .out_valid (out_valid),
    .quotient  (h_q),
    .side_out  (h_side)
  );

  // grey pixel: hue forced to zero
  assign sat = h_side[SW2-1:C+1];
  assign val = h_side[C:1];
  assign hue = h_side[0] ? '0 : h_q;

endmodule

### rtl/hca_hsv2rgb.sv
// hca_hsv2rgb: offset/clamp stage and HSV to RGB six-sector back end.
// Depends on hca_pkg for offset register widths.
module hca_hsv2rgb import hca_pkg::*; #(
  parameter int C = 8,
  parameter int H = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [H-1:0]         hue,
  input  logic [C-1:0]         sat,
  input  logic [C-1:0]         val,
  input  logic [HUE_OFS_W-1:0] hue_offset,
  input  logic [SV_OFS_W-1:0]  saturation_offset,
  input  logic [SV_OFS_W-1:0]  value_offset,
  output logic                 out_valid,
  output logic [C-1:0]         red,
  output logic [C-1:0]         green,
  output logic [C-1:0]         blue
);

  localparam int HW = ((H > HUE_OFS_W) ? H : HUE_OFS_W) + 1;
  localparam int CW = ((C > SV_OFS_W) ? C : SV_OFS_W) + 2;
  localparam logic [C-1:0]   CMAX = {C{1'b1}};
  localparam logic [C+H-1:0] ONE  = {CMAX, H'(0)};

  // floor(v / CMAX), exact for v up to CMAX * CMAX
  function automatic logic [C-1:0] div_cmax(input logic [2*C-1:0] v);
    logic [2*C:0] w;
    w = {1'b0, v} + (2*C+1)'(v >> C) + (2*C+1)'(1);
    return w[2*C-1:C];
  endfunction

  function automatic logic [C-1:0] clamp_add(input logic [C-1:0] a,
                                              input logic [SV_OFS_W-1:0] o);
    logic signed [CW-1:0] s;
    s = $signed(CW'(a)) + CW'($signed(o));
    if (s < 0) return '0;
    if (s > $signed(CW'(CMAX))) return CMAX;
    return s[C-1:0];
  endfunction

  // stage 1: offsets
  logic           v1;
  logic [H-1:0]   h1;
  logic [C-1:0]   s1, l1;
  logic [HW-1:0]  hsum;

  assign hsum = HW'(hue) + HW'($signed(hue_offset));

  // stage 2: sector split, x numerator
  logic           v2;
  logic [2:0]     sec2;
  logic [H-1:0]   f2;
  logic [C-1:0]   s2, l2;
  logic [2*C-1:0] xn2;
  logic [H+2:0]   t1;
  logic [C+H-1:0] sf2;

  assign t1  = ({3'b0, h1} << 2) + ({3'b0, h1} << 1);
  assign sf2 = s2 * f2;

  // stage 3: sat * fraction products
  logic           v3;
  logic [2:0]     sec3;
  logic [C-1:0]   l3, x3;
  logic [C+H-1:0] sf3;
  logic [C+H:0]   sg3;

  // stage 4: value products
  logic           v4;
  logic [2:0]     sec4;
  logic [C-1:0]   l4, x4;
  logic [2*C+H-1:0] yp4, zp4;
  logic [C+H:0]   zw;

  assign zw = {1'b0, ONE} - sg3;

  // stage 5: output register
  logic [C-1:0]   y5, z5;

  assign y5 = div_cmax(yp4[2*C+H-1:H]);
  assign z5 = div_cmax(zp4[2*C+H-1:H]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1   <= hsum[H-1:0];
      s1   <= clamp_add(sat, saturation_offset);
      l1   <= clamp_add(val, value_offset);

      sec2 <= t1[H+2:H];
      f2   <= t1[H-1:0];
      s2   <= s1;
      l2   <= l1;
      xn2  <= l1 * (CMAX - s1);

      sec3 <= sec2;
      l3   <= l2;
      x3   <= div_cmax(xn2);
      sf3  <= sf2;
      // sat * (turn - f)
      sg3  <= {1'b0, s2, H'(0)} - {1'b0, sf2};

      sec4 <= sec3;
      l4   <= l3;
      x4   <= x3;
      yp4  <= l3 * (ONE - sf3);
      zp4  <= l3 * zw[C+H-1:0];

      case (sec4)
        3'd1: begin red <= y5; green <= l4; blue <= x4; end
        3'd2: begin red <= x4; green <= l4; blue <= z5; end
        3'd3: begin red <= x4; green <= y5; blue <= l4; end
        3'd4: begin red <= z5; green <= x4; blue <= l4; end
        3'd5: begin red <= l4; green <= x4; blue <= y5; end
        default: begin red <= l4; green <= z5; blue <= x4; end
      endcase
    end
  end

endmodule

### rtl/hsv_color_adjust.sv
// hsv_color_adjust: RGB pixel in, hue/saturation/value adjusted RGB pixel out.
// One pixel is taken every clock while the output side keeps up; a pixel passes
// through the max/min register, then the two bit-per-stage dividers for saturation
// and hue, then the offset/clamp and six-sector back end stages.
// A stall at the output freezes the whole pipeline. Offsets sit in an APB
// register file at 0x0 (hue), 0x4 (saturation), 0x8 (value); write them
// only while no pixels are in flight. Depends on hca_pkg, hca_if and submodules.
module hsv_color_adjust import hca_pkg::*; #(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  hca_in_if.sink            pix_in,
  hca_out_if.source         pix_out
);

  logic [HUE_OFS_W-1:0] hue_offset;
  logic [SV_OFS_W-1:0]  saturation_offset;
  logic [SV_OFS_W-1:0]  value_offset;
  logic                 en;
  logic                 fe_valid;
  logic [HUE_BITS-1:0]  fe_hue;
  logic [CHANNEL_BITS-1:0] fe_sat, fe_val;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset        <= '0;
      saturation_offset <= '0;
      value_offset      <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_HUE_OFS: hue_offset        <= pwdata[HUE_OFS_W-1:0];
        REG_SAT_OFS: saturation_offset <= pwdata[SV_OFS_W-1:0];
        REG_VAL_OFS: value_offset      <= pwdata[SV_OFS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HUE_OFS: prdata = DATA_W'(hue_offset);
      REG_SAT_OFS: prdata = DATA_W'(saturation_offset);
      REG_VAL_OFS: prdata = DATA_W'(value_offset);
      default:     prdata = '0;
    endcase
  end

  // global advance: output register empty or being drained
  assign en           = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  hca_rgb2hsv #(.C(CHANNEL_BITS), .H(HUE_BITS)) u_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pix_in.valid),
    .red       (pix_in.red_in),
    .green     (pix_in.green_in),
    .blue      (pix_in.blue_in),
    .out_valid (fe_valid),
    .hue       (fe_hue),
    .sat       (fe_sat),
    .val       (fe_val)
  );

  hca_hsv2rgb #(.C(CHANNEL_BITS), .H(HUE_BITS)) u_back (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .in_valid          (fe_valid),
    .hue               (fe_hue),
    .sat               (fe_sat),
    .val               (fe_val),
    .hue_offset        (hue_offset),
    .saturation_offset (saturation_offset),
    .value_offset      (value_offset),
    .out_valid         (pix_out.valid),
    .red               (pix_out.red_out),
    .green             (pix_out.green_out),
    .blue              (pix_out.blue_out)
  );

endmodule

### dv/hsv_color_adjust_tb.sv
// hsv_color_adjust_tb: drives RGB pixels into hsv_color_adjust, predicts each adjusted
// pixel in integer HSV arithmetic and checks the output stream and the APB registers.
// Depends on hca_pkg, hca_if and the hsv_color_adjust RTL.
`timescale 1ns / 1ps
module hsv_color_adjust_tb;
  import hca_pkg::*;

  localparam int CBITS = 8;
  localparam int HBITS = 16;
  localparam longint unsigned CFULL = (1 << CBITS) - 1;
  localparam longint unsigned TURN  = 1 << HBITS;
  localparam int DRAIN = 40;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  hca_in_if  #(.W(CBITS)) pix_in ();
  hca_out_if #(.W(CBITS)) pix_out ();

  hsv_color_adjust #(.CHANNEL_BITS(CBITS), .HUE_BITS(HBITS)) u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pix_in(pix_in.sink), .pix_out(pix_out.source)
  );

  always #10 clk = ~clk;

  logic [16:0] hue_shift;
  logic [8:0]  sat_shift;
  logic [8:0]  val_shift;
  pixel_t      adjusted_q[$];
  int          src_idle_pct, snk_idle_pct;
  int          n_sent, n_checked, n_errors;

  function automatic longint unsigned clamp_chan(longint v);
    if (v < 0) return 0;
    if (v > longint'(CFULL)) return CFULL;
    return v;
  endfunction

  function automatic pixel_t adjust_pixel(pixel_t p);
    longint unsigned r, g, b, mx, mn, d, sat, hue, val, one, t, sector, f, x, y, z;
    longint num;
    pixel_t o;
    r = p.red; g = p.green; b = p.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    val = mx;
    sat = (mx > 0) ? d * CFULL / mx : 0;
    hue = 0;
    if (sat != 0) begin
      if (r == mx) num = longint'(g) - longint'(b);
      else if (g == mx) num = 2 * longint'(d) + longint'(b) - longint'(r);
      else num = 4 * longint'(d) + longint'(r) - longint'(g);
      if (num < 0) num += 6 * longint'(d);
      hue = (unsigned'(num) << HBITS) / (6 * d);
    end
    hue = unsigned'(longint'(hue) + longint'(signed'(hue_shift))) & (TURN - 1);
    sat = clamp_chan(longint'(sat) + longint'(signed'(sat_shift)));
    val = clamp_chan(longint'(val) + longint'(signed'(val_shift)));
    one = CFULL << HBITS;
    t = hue * 6;
    sector = t >> HBITS;
    f = t & (TURN - 1);
    x = val * (CFULL - sat) / CFULL;
    y = val * (one - sat * f) / one;
    z = val * (one - sat * (TURN - f)) / one;
    case (sector)
      1: o = '{y[7:0], val[7:0], x[7:0]};
      2: o = '{x[7:0], val[7:0], z[7:0]};
      3: o = '{x[7:0], y[7:0], val[7:0]};
      4: o = '{z[7:0], x[7:0], val[7:0]};
      5: o = '{val[7:0], x[7:0], y[7:0]};
      default: o = '{val[7:0], z[7:0], x[7:0]};
    endcase
    return o;
  endfunction

  function automatic void mismatch(string what, longint e, longint a);
    n_errors++;
    if (n_errors <= 10)
      $display("[%0t] mismatch %s: expected %0h got %0h", $realtime, what, e, a);
  endfunction

  // output checker with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      pix_out.ready <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (adjusted_q.size() == 0) begin
          mismatch("unexpected transaction", 0, 1);
        end else begin
          pixel_t e;
          e = adjusted_q.pop_front();
          if (pix_out.red_out !== e.red) mismatch("red", e.red, pix_out.red_out);
          if (pix_out.green_out !== e.green) mismatch("green", e.green, pix_out.green_out);
          if (pix_out.blue_out !== e.blue) mismatch("blue", e.blue, pix_out.blue_out);
          n_checked++;
        end
      end
      pix_out.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // valid stays high after an accept so the next pixel can follow directly
  task automatic send_pixel(pixel_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.red_in <= p.red;
    pix_in.green_in <= p.green;
    pix_in.blue_in <= p.blue;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    adjusted_q.push_back(adjust_pixel(p));
    n_sent++;
  endtask

  task automatic wait_idle();
    int guard;
    pix_in.valid <= 1'b0;
    guard = 0;
    while (adjusted_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_HUE_OFS: hue_shift = v[16:0];
      REG_SAT_OFS: sat_shift = v[8:0];
      REG_VAL_OFS: val_shift = v[8:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apb_check(logic [1:0] idx, logic [31:0] e);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_W'(idx) << 2;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    #1;
    if (prdata[16:0] !== e[16:0]) mismatch("register read", e, prdata);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_offsets(logic [16:0] h, logic [8:0] s, logic [8:0] v);
    wait_idle();
    apb_write(REG_HUE_OFS, {15'd0, h});
    apb_write(REG_SAT_OFS, {23'd0, s});
    apb_write(REG_VAL_OFS, {23'd0, v});
    apb_check(REG_HUE_OFS, {15'd0, h});
    apb_check(REG_SAT_OFS, {23'd0, s});
    apb_check(REG_VAL_OFS, {23'd0, v});
  endtask

  task automatic test_directed();
    pixel_t corner[$];
    corner = '{'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd128, 8'd128, 8'd128},
               '{8'd255, 8'd0, 8'd0}, '{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255},
               '{8'd255, 8'd255, 8'd0}, '{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255},
               '{8'd255, 8'd0, 8'd1}, '{8'd1, 8'd0, 8'd0}, '{8'd200, 8'd200, 8'd10},
               '{8'd10, 8'd200, 8'd200}, '{8'd170, 8'd85, 8'd255}, '{8'd1, 8'd2, 8'd3}};
    foreach (corner[i]) send_pixel(corner[i]);
    // full-turn hue wrap and offsets at their extremes
    set_offsets(17'h10000, 9'h0FF, 9'h101);
    foreach (corner[i]) if (i < 6) send_pixel(corner[i]);
    set_offsets(17'h10001, 9'h101, 9'h0FF);
    foreach (corner[i]) if (i < 6) send_pixel(corner[i]);
  endtask

  task automatic test_random(int n, bit fixed_cfg);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      if (!fixed_cfg && i % 40 == 0)
        set_offsets(17'($urandom), 9'($urandom), 9'($urandom));
      p = pixel_t'(24'($urandom));
      if ($urandom_range(9) == 0) p.green = p.red;
      if ($urandom_range(9) == 0) p.blue = p.red;
      send_pixel(p);
    end
  endtask

  initial begin
    pix_in.valid = 1'b0;
    pix_in.red_in = '0;
    pix_in.green_in = '0;
    pix_in.blue_in = '0;
    hue_shift = '0; sat_shift = '0; val_shift = '0;
    n_sent = 0; n_checked = 0; n_errors = 0;
    src_idle_pct = 22; snk_idle_pct = 81;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(170, 1'b0);
    src_idle_pct = 81; snk_idle_pct = 22;
    test_random(170, 1'b0);
    src_idle_pct = 0; snk_idle_pct = 0;
    set_offsets(17'd0, 9'd0, 9'd0);
    test_random(160, 1'b1);
    wait_idle();
    $display("covered %0d pixels, %0d checked, across several offset settings and stall mixes",
             n_sent, n_checked);
    if (n_errors == 0 && adjusted_q.size() == 0) begin
      $display("hsv_color_adjust_tb: clean");
    end else begin
      $display("mismatches %0d, pixels still expected %0d", n_errors, adjusted_q.size());
      $display("hsv_color_adjust_tb: errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("hsv_color_adjust_tb: errors");
    $finish;
  end
endmodule
